/* src/hcf_pkg.sv */
// Shared types and constants for the host command framer and read chunker.
`timescale 1ns / 1ps
`default_nettype none
package hcf_pkg;

	localparam int unsigned CNT_W = 5;

	localparam logic [7:0] CHR_R = 8'h72;
	localparam logic [7:0] CHR_D = 8'h64;
	localparam logic [7:0] CHR_G = 8'h67;
	localparam logic [7:0] CHR_W = 8'h77;
	localparam logic [7:0] CHR_T = 8'h74;

	localparam logic [7:0]  RESET_DEVICE  = 8'h33;
	localparam logic [15:0] RESET_ADDRESS = 16'h2000;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_CHUNK = 2'd2,
		ACT_DONE  = 2'd3
	} action_t;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic        is_read;
		logic        is_write;
		logic [7:0]  dev;
		logic [15:0] addr;
		logic [15:0] val;
	} frame_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  dev;
		logic [15:0] addr;
		logic [15:0] val;
		logic        drop;
	} result_t;

endpackage
`default_nettype wire

/* src/hcf_window.sv */
// Eight-byte host window, resync count and command match.
`timescale 1ns / 1ps
`default_nettype none
module hcf_window
	import hcf_pkg::*;
#(
	parameter int unsigned WINDOW_SPAN = 30
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_fire,
	input  wire logic [7:0] host_byte,
	output frame_t          frame
);

	logic [7:0]       win_q [8];
	logic [7:0]       nxt   [8];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	logic             hit;

	always_comb begin
		for (int i = 0; i < 7; i++) begin
			nxt[i] = win_q[i+1];
		end
		nxt[7] = host_byte;
	end

	assign cnt_inc = cnt_q + CNT_W'(1);

	always_comb begin
		frame.is_read  = (cnt_inc >= CNT_W'(8)) && nxt[5] == CHR_R && nxt[6] == CHR_D
			&& nxt[7] == CHR_G;
		frame.is_write = (cnt_inc >= CNT_W'(8)) && nxt[5] == CHR_W && nxt[6] == CHR_R
			&& nxt[7] == CHR_T;
		frame.dev      = nxt[0];
		frame.addr     = {nxt[1], nxt[2]};
		frame.val      = {nxt[3], nxt[4]};
	end

	assign hit = frame.is_read || frame.is_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				win_q[i] <= 8'd0;
			end
			cnt_q <= '0;
		end else if (byte_fire) begin
			for (int i = 0; i < 8; i++) begin
				win_q[i] <= nxt[i];
			end
			if (hit || cnt_inc >= CNT_W'(WINDOW_SPAN)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

`ifndef SYNTHESIS
	a_match_resync: assert property (@(posedge clk) disable iff (!arst_n)
		byte_fire && hit |=> cnt_q == '0)
		else $error("count not cleared after command match");
`endif

endmodule
`default_nettype wire

/* src/hcf_chunker.sv */
// Read state, chunk splitting and result selection.
`timescale 1ns / 1ps
`default_nettype none
module hcf_chunker
	import hcf_pkg::*;
#(
	parameter int unsigned CHUNK_BYTES = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fire,
	input  wire opcode_t  opcode,
	input  wire frame_t   frame,
	output logic          pending,
	output logic          res_valid,
	output result_t       res
);

	localparam logic [15:0] CHUNK = 16'(CHUNK_BYTES);

	logic        pend_q;
	logic [7:0]  dev_q;
	logic [15:0] addr_q;
	logic [15:0] rem_q;

	logic        pend_d;
	logic [7:0]  dev_d;
	logic [15:0] addr_d;
	logic [15:0] rem_d;

	logic [15:0] len_cur;
	logic [15:0] rem_adv;
	logic [15:0] addr_adv;
	logic [15:0] len_adv;
	logic [15:0] len_cmd;

	assign pending  = pend_q;
	assign len_cur  = (rem_q > CHUNK) ? CHUNK : rem_q;
	assign rem_adv  = rem_q - len_cur;
	assign addr_adv = addr_q + {1'b0, len_cur[15:1]};
	assign len_adv  = (rem_adv > CHUNK) ? CHUNK : rem_adv;
	assign len_cmd  = (frame.val > CHUNK) ? CHUNK : frame.val;

	always_comb begin
		pend_d    = pend_q;
		dev_d     = dev_q;
		addr_d    = addr_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '{action: ACT_NONE, dev: dev_q, addr: addr_q, val: rem_q, drop: 1'b0};
		if (opcode == OP_ADVANCE) begin
			if (pend_q) begin
				res_valid = 1'b1;
				rem_d     = rem_adv;
				addr_d    = addr_adv;
				res.addr  = addr_adv;
				if (rem_adv == 16'd0) begin
					pend_d     = 1'b0;
					res.action = ACT_DONE;
					res.val    = 16'd0;
				end else begin
					res.action = ACT_CHUNK;
					res.val    = len_adv;
				end
			end
		end else if (pend_q) begin
			res_valid = 1'b1;
			res.drop  = 1'b1;
		end else if (frame.is_write) begin
			res_valid = 1'b1;
			res       = '{action: ACT_WRITE, dev: frame.dev, addr: frame.addr,
				val: frame.val, drop: 1'b0};
		end else if (frame.is_read) begin
			res_valid = 1'b1;
			dev_d     = frame.dev;
			addr_d    = frame.addr;
			rem_d     = frame.val;
			if (frame.val == 16'd0) begin
				res = '{action: ACT_DONE, dev: frame.dev, addr: frame.addr,
					val: 16'd0, drop: 1'b0};
			end else begin
				pend_d = 1'b1;
				res    = '{action: ACT_CHUNK, dev: frame.dev, addr: frame.addr,
					val: len_cmd, drop: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			dev_q  <= RESET_DEVICE;
			addr_q <= RESET_ADDRESS;
			rem_q  <= 16'd0;
		end else if (fire) begin
			pend_q <= pend_d;
			dev_q  <= dev_d;
			addr_q <= addr_d;
			rem_q  <= rem_d;
		end
	end

`ifndef SYNTHESIS
	a_pend_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> rem_q != 16'd0)
		else $error("read pending with nothing remaining");

	a_chunk_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.action == ACT_CHUNK |-> res.val != 16'd0 && res.val <= CHUNK)
		else $error("chunk length out of range");
`endif

endmodule
`default_nettype wire

/* src/host_command_framer_read_chunker.sv */
// Top level: input register, framer, chunker and result register.
//
//  channel | signals                                              | dir
//  in      | in_valid, in_ready, opcode, host_byte                | to block
//  out     | out_valid, out_ready, action, device_address,        | from block
//          | register_address, value_or_length, dropped_byte      |
//
// One word per cycle while the result register is empty or being drained: a
// word waits in the input register, and its result, if any, is registered in
// the result register when the word moves on.
// The input register moves on whenever the result register is empty or is
// being drained, so a stalled sink holds one result and one pending word.
// Reset is asynchronous; window clears, read device 0x33, address 0x2000.
`timescale 1ns / 1ps
`default_nettype none
module host_command_framer_read_chunker
	import hcf_pkg::*;
#(
	parameter int unsigned CHUNK_BYTES = 64,
	parameter int unsigned WINDOW_SPAN = 30
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [7:0]  host_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       action,
	output logic [7:0]       device_address,
	output logic [15:0]      register_address,
	output logic [15:0]      value_or_length,
	output logic             dropped_byte
);

	logic       valid_s1;
	opcode_t    opcode_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic       pending;
	logic       byte_fire;
	logic       res_valid;
	frame_t     frame;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire;
	assign byte_fire = fire && opcode_s1 == OP_BYTE && !pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode_t'(opcode);
			byte_s1   <= host_byte;
		end
	end

	hcf_window #(
		.WINDOW_SPAN(WINDOW_SPAN)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_fire(byte_fire),
		.host_byte(byte_s1),
		.frame    (frame)
	);

	hcf_chunker #(
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_chunker (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.opcode   (opcode_s1),
		.frame    (frame),
		.pending  (pending),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign action           = out_q.action;
	assign device_address   = out_q.dev;
	assign register_address = out_q.addr;
	assign value_or_length  = out_q.val;
	assign dropped_byte     = out_q.drop;

`ifndef SYNTHESIS
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |=> out_valid_q)
		else $error("result lost on its way to the output register");
`endif

endmodule
`default_nettype wire
